FILE: sv/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PJQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pjq assertion failed");

// Next-cycle implication.
`define PJQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pjq assertion failed");

`endif

FILE: sv/pjq_pkg.sv
package pjq_pkg;

  localparam int TDATA_W = 64;
  localparam int ENTRY_W = 5;
  localparam logic URGENT_LEVEL = 1'b1;

  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_PEEK   = 2'd1,
    MODE_DEQ    = 2'd2,
    MODE_CANCEL = 2'd3
  } pjq_mode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } pjq_status_t;

  // id in the low bits, same order as the item bus
  typedef struct packed {
    logic [15:0] ms;
    logic [7:0]  copies;
    logic [15:0] pages;
    logic        urgent;
    logic [15:0] id;
  } pjq_job_t;

  localparam int JOB_W = $bits(pjq_job_t);

  typedef struct packed {
    logic        cap;
    logic        step;
    logic        scan_step;
    logic        enq_commit;
    logic        take_commit;
    logic        res_ld;
    logic        res_ok;
    logic        res_job;
    pjq_status_t res_status;
    logic        out_ld;
  } pjq_cmd_t;

  typedef struct packed {
    pjq_mode_t mode;
    logic      held_zero;
    logic      full;
    logic      slot_free;
    logic      id_match;
    logic      walk_last;
  } pjq_sts_t;

endpackage

FILE: sv/pjq_ctrl.sv
module pjq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  pjq_pkg::pjq_mode_t in_mode,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  pjq_pkg::pjq_sts_t  sts,
  output pjq_pkg::pjq_cmd_t  cmd
);
  import pjq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WALK, S_PUSH} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap = 1'b1;
          if (in_mode == MODE_ENQ) begin
            if (sts.full) begin
              cmd.res_ld     = 1'b1;
              cmd.res_status = ST_FULL;
              state_nxt      = S_PUSH;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (sts.held_zero) begin
            cmd.res_ld     = 1'b1;
            cmd.res_status = ST_EMPTY;
            state_nxt      = S_PUSH;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_SCAN: begin
        if (sts.slot_free) begin
          cmd.enq_commit = 1'b1;
          cmd.res_ld     = 1'b1;
          cmd.res_ok     = 1'b1;
          cmd.res_status = ST_DONE;
          state_nxt      = S_PUSH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_WALK: begin
        unique case (sts.mode)
          MODE_PEEK: begin
            cmd.res_ld     = 1'b1;
            cmd.res_ok     = 1'b1;
            cmd.res_job    = 1'b1;
            cmd.res_status = ST_DONE;
            state_nxt      = S_PUSH;
          end
          MODE_DEQ: begin
            cmd.take_commit = 1'b1;
            cmd.res_ld      = 1'b1;
            cmd.res_ok      = 1'b1;
            cmd.res_job     = 1'b1;
            cmd.res_status  = ST_DONE;
            state_nxt       = S_PUSH;
          end
          MODE_CANCEL: begin
            if (sts.id_match) begin
              cmd.take_commit = 1'b1;
              cmd.res_ld      = 1'b1;
              cmd.res_ok      = 1'b1;
              cmd.res_job     = 1'b1;
              cmd.res_status  = ST_DONE;
              state_nxt       = S_PUSH;
            end else if (sts.walk_last) begin
              cmd.res_ld     = 1'b1;
              cmd.res_status = ST_NOT_FOUND;
              state_nxt      = S_PUSH;
            end else begin
              cmd.step = 1'b1;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_PUSH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.out_ld | (out_valid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

FILE: sv/pjq_dpath.sv
module pjq_dpath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [pjq_pkg::TDATA_W-1:0]  in_tdata,
  input  pjq_pkg::pjq_mode_t           in_mode,
  input  pjq_pkg::pjq_cmd_t            cmd,
  output pjq_pkg::pjq_sts_t            sts,
  output logic [pjq_pkg::TDATA_W-1:0]  out_tdata,
  output logic [2:0]                   out_tuser
);
  import pjq_pkg::*;

  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  pjq_job_t           job_mem [QUEUE_DEPTH];
  logic [SLOT_W-1:0]  link_mem [QUEUE_DEPTH];

  pjq_mode_t          mode_r;
  pjq_job_t           job_in_r;
  pjq_job_t           rd_job_r;
  logic [SLOT_W-1:0]  link_rd_r;
  logic [SLOT_W-1:0]  rd_addr;

  logic [SLOT_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [QUEUE_DEPTH-1:0] free_r, free_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [SLOT_W-1:0]  cur_r, prev_r, idx_r, i_r;

  logic               link_we;
  logic [SLOT_W-1:0]  link_waddr, link_wdata;

  logic               res_ok_r;
  pjq_status_t        res_status_r;
  pjq_job_t           res_job_r;
  logic               out_ok_r;
  pjq_status_t        out_status_r;
  pjq_job_t           out_job_r;
  logic [ENTRY_W-1:0] out_entry_r;

  // next read follows the link while walking, else the head
  assign rd_addr = cmd.step ? link_rd_r : head_r;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    free_nxt   = free_r;
    held_nxt   = held_r;
    link_we    = 1'b0;
    link_waddr = tail_r;
    link_wdata = idx_r;
    if (cmd.enq_commit) begin
      free_nxt[idx_r] = 1'b0;
      held_nxt        = held_r + CNT_W'(1);
      if (held_r == '0) begin
        head_nxt = idx_r;
        tail_nxt = idx_r;
      end else if (job_in_r.urgent == URGENT_LEVEL) begin
        link_we    = 1'b1;
        link_waddr = idx_r;
        link_wdata = head_r;
        head_nxt   = idx_r;
      end else begin
        link_we    = 1'b1;
        link_waddr = tail_r;
        link_wdata = idx_r;
        tail_nxt   = idx_r;
      end
    end
    if (cmd.take_commit) begin
      free_nxt[cur_r] = 1'b1;
      held_nxt        = held_r - CNT_W'(1);
      if (i_r == '0) begin
        head_nxt = link_rd_r;
      end else begin
        link_we    = 1'b1;
        link_waddr = prev_r;
        link_wdata = link_rd_r;
      end
      if (cur_r == tail_r) begin
        tail_nxt = prev_r;
      end
      if (held_r == CNT_W'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      free_r <= '1;
      held_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      free_r <= free_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r   <= in_mode;
      job_in_r <= pjq_job_t'(in_tdata[JOB_W-1:0]);
      cur_r    <= head_r;
      prev_r   <= head_r;
      i_r      <= '0;
      idx_r    <= '0;
    end else begin
      if (cmd.step) begin
        prev_r <= cur_r;
        cur_r  <= link_rd_r;
        i_r    <= i_r + SLOT_W'(1);
      end
      if (cmd.scan_step) begin
        idx_r <= idx_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_commit) begin
      job_mem[idx_r] <= job_in_r;
    end
    rd_job_r <= job_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_r <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_ok_r     <= cmd.res_ok;
      res_status_r <= cmd.res_status;
      res_job_r    <= cmd.res_job ? rd_job_r : '0;
    end
    if (cmd.out_ld) begin
      out_ok_r     <= res_ok_r;
      out_status_r <= res_status_r;
      out_job_r    <= res_job_r;
      out_entry_r  <= ENTRY_W'(held_r);
    end
  end

  always_comb begin
    sts.mode      = mode_r;
    sts.held_zero = (held_r == '0);
    sts.full      = (held_r == CNT_W'(QUEUE_DEPTH));
    sts.slot_free = free_r[idx_r];
    sts.id_match  = (rd_job_r.id == job_in_r.id);
    sts.walk_last = ((CNT_W'(i_r) + CNT_W'(1)) == held_r);
  end

  assign out_tdata = TDATA_W'({out_entry_r, out_job_r});
  assign out_tuser = {out_status_r, out_ok_r};

endmodule

FILE: sv/priority_job_queue_with_cancel_core.sv
// From accept to result valid: empty and full results load at accept; peek and dequeue
// read the head; cancel walks from the head, one slot visited per cycle, to a match or
// the end; enqueue scans the free map one bit per cycle for the lowest free slot.
// One item in flight: in_tready returns in the same cycle its result first shows valid;
// a held result stalls the next one in the output load.
// Reset is synchronous, active low: head, tail, count and free map clear; memories do not.
module priority_job_queue_with_cancel_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // job_id[15:0], urgent[16], page_total[32:17], copy_count[40:33], ms_per_page[56:41]
  input  logic [pjq_pkg::TDATA_W-1:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_id[15:0], out_urgent[16], out_pages[32:17], out_copies[40:33], out_ms[56:41],
  // entry_total[61:57]
  output logic [pjq_pkg::TDATA_W-1:0] out_tdata,
  // ok[0], status[2:1]
  output logic [2:0]                  out_tuser
);
  import pjq_pkg::*;

  pjq_cmd_t  cmd;
  pjq_sts_t  sts;
  pjq_mode_t in_mode;

  assign in_mode = pjq_mode_t'(in_tuser);

  pjq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_mode),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pjq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_mode   (in_mode),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

FILE: sv/pjq_checker.sv
`include "assert_macros.svh"

module pjq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [pjq_pkg::TDATA_W-1:0] in_tdata,
  input logic [1:0]                  in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [pjq_pkg::TDATA_W-1:0] out_tdata,
  input logic [2:0]                  out_tuser
);
  import pjq_pkg::*;

  `PJQ_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `PJQ_ASSERT_NXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)
  `PJQ_ASSERT_IMP(a_ok_done, out_tvalid, out_tuser[0] == (out_tuser[2:1] == ST_DONE))
  `PJQ_ASSERT_IMP(a_fail_no_job, out_tvalid && !out_tuser[0], out_tdata[JOB_W-1:0] == '0)
  `PJQ_ASSERT_IMP(a_empty_count, out_tvalid && (out_tuser[2:1] == ST_EMPTY), out_tdata[JOB_W+ENTRY_W-1:JOB_W] == '0)

endmodule

bind priority_job_queue_with_cancel_core pjq_checker u_pjq_checker (.*);
